[rtl/core/worker_restart_supervisor_macros.svh]
// assertion macros for the worker restart supervisor
`ifndef WORKER_RESTART_SUPERVISOR_MACROS_SVH
`define WORKER_RESTART_SUPERVISOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define WRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define WRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wrs_pkg.sv]
// shared types, codes and helpers for the worker restart supervisor
package wrs_pkg;

  localparam int ID_BITS       = 16;
  localparam int TIME_BITS     = 32;
  localparam int CMD_BITS      = 3;
  localparam int ACTION_BITS   = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CMD_BITS-1:0] CMD_BEGIN_ACTIVATION = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_BEGIN_ATTEMPT    = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_HEARTBEAT        = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_HEALTH_CHECK     = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_WORKER_EXITED    = 3'd4;

  localparam logic [ACTION_BITS-1:0] ACT_NONE     = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_RESTART  = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_ROLLBACK = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_DUP      = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_STALE    = 3'd4;
  localparam logic [ACTION_BITS-1:0] ACT_REFUSED  = 3'd5;

  localparam logic [CFG_IDX_BITS-1:0] REG_HEARTBEAT_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEALTH_WINDOW     = 2'd1;

  localparam logic [TIME_BITS-1:0] HEARTBEAT_TIMEOUT_RESET = 32'd1000;
  localparam logic [TIME_BITS-1:0] HEALTH_WINDOW_RESET     = 32'd10000;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_RETIRED = 2'd2
  } sup_state_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]  command;
    logic [ID_BITS-1:0]   activation_id;
    logic [ID_BITS-1:0]   attempt_id;
    logic [TIME_BITS-1:0] now_ms;
    logic                 exit_clean;
  } event_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [ID_BITS-1:0]     id_out;
    logic                   id_valid;
    logic                   restart_fire;
    logic                   rollback_fire;
    logic [ID_BITS-1:0]     fired_activation;
    logic [1:0]             supervisor_state;
    logic                   crash_loop;
    logic                   attempt_active;
  } result_t;

  // ids skip zero when they wrap
  function automatic logic [ID_BITS-1:0] advance_id(input logic [ID_BITS-1:0] id);
    logic [ID_BITS-1:0] nxt;
    if (&id) begin
      nxt = {{(ID_BITS-1){1'b0}}, 1'b1};
    end else begin
      nxt = id + {{(ID_BITS-1){1'b0}}, 1'b1};
    end
    return nxt;
  endfunction

endpackage

[rtl/core/worker_restart_supervisor.sv]
// top level of the worker restart supervisor
`include "worker_restart_supervisor_macros.svh"

// Worker restart supervisor. Every event word (begin activation, begin attempt,
// heartbeat, health check, worker exited) is decided in the cycle it is
// accepted; its one result word is registered toward out_data, so the block
// takes one event per clock while in_stall is low; the rate is set by the
// single state update per event, which only needs id compares, two widened
// time adds and flag logic. Results leave through an output register backed
// by one skid entry, so input keeps flowing while a result waits; in_stall
// rises only while both hold a word. The configuration port is always ready
// (cfg_ready high) and is meant to be written while no event is in flight; a
// timing register written as zero makes both limits fall back to their reset
// values while it stays zero. Ids wrap from all ones to 1, never to 0.
module worker_restart_supervisor
  import wrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  event_t                   in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output result_t                  out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  logic [TIME_BITS-1:0] heartbeat_timeout;
  logic [TIME_BITS-1:0] health_window;

  // supervisor state
  logic [ID_BITS-1:0]   current_activation, current_activation_next;
  logic [ID_BITS-1:0]   current_attempt, current_attempt_next;
  sup_state_t           sup_state, sup_state_next;
  logic [TIME_BITS-1:0] window_start, window_start_next;
  logic [TIME_BITS-1:0] last_beat, last_beat_next;
  logic                 restart_spent, restart_spent_next;
  logic                 rollback_done, rollback_done_next;
  logic                 attempt_exists, attempt_exists_next;
  logic                 failed_known, failed_known_next;
  logic [ID_BITS-1:0]   failed_activation, failed_activation_next;
  logic [ID_BITS-1:0]   failed_attempt, failed_attempt_next;
  logic                 loop_flag, loop_flag_next;

  // output register plus skid entry
  logic    skid_valid;
  result_t skid_data;
  result_t result;

  logic push, pop;

  // timing limits and widened sums
  logic                 limit_fallback;
  logic [TIME_BITS-1:0] limit_beat, limit_window;
  logic [TIME_BITS:0]   beat_deadline, window_deadline;
  logic                 key_current, key_failed, beat_missed, fail_event;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  assign limit_fallback  = (heartbeat_timeout == '0) || (health_window == '0);
  assign limit_beat      = limit_fallback ? HEARTBEAT_TIMEOUT_RESET : heartbeat_timeout;
  assign limit_window    = limit_fallback ? HEALTH_WINDOW_RESET : health_window;
  assign beat_deadline   = {1'b0, last_beat} + {1'b0, limit_beat};
  assign window_deadline = {1'b0, window_start} + {1'b0, limit_window};

  assign key_current = attempt_exists && (in_data.activation_id == current_activation)
                       && (in_data.attempt_id == current_attempt);
  assign key_failed  = failed_known && (in_data.activation_id == failed_activation)
                       && (in_data.attempt_id == failed_attempt);
  assign beat_missed = {1'b0, in_data.now_ms} > beat_deadline;

  // a failure of the current running attempt: missed beat or unclean exit
  assign fail_event = !key_failed && key_current && (sup_state == ST_RUNNING)
                      && (((in_data.command == CMD_HEALTH_CHECK) && beat_missed)
                          || ((in_data.command == CMD_WORKER_EXITED) && !in_data.exit_clean));

  // event decode and next state
  always_comb begin
    current_activation_next = current_activation;
    current_attempt_next    = current_attempt;
    sup_state_next          = sup_state;
    window_start_next       = window_start;
    last_beat_next          = last_beat;
    restart_spent_next      = restart_spent;
    rollback_done_next      = rollback_done;
    attempt_exists_next     = attempt_exists;
    failed_known_next       = failed_known;
    failed_activation_next  = failed_activation;
    failed_attempt_next     = failed_attempt;
    loop_flag_next          = loop_flag;
    result                  = '0;

    case (in_data.command)
      CMD_BEGIN_ACTIVATION: begin
        current_activation_next = advance_id(current_activation);
        sup_state_next          = ST_STOPPED;
        window_start_next       = in_data.now_ms;
        last_beat_next          = in_data.now_ms;
        restart_spent_next      = 1'b0;
        rollback_done_next      = 1'b0;
        attempt_exists_next     = 1'b0;
        failed_known_next       = 1'b0;
        loop_flag_next          = 1'b0;
        result.id_out           = current_activation_next;
        result.id_valid         = 1'b1;
      end
      CMD_BEGIN_ATTEMPT: begin
        if ((in_data.activation_id != current_activation) || (sup_state != ST_STOPPED)
            || loop_flag) begin
          result.action = ACT_REFUSED;
        end else begin
          current_attempt_next = advance_id(current_attempt);
          attempt_exists_next  = 1'b1;
          sup_state_next       = ST_RUNNING;
          last_beat_next       = in_data.now_ms;
          result.id_out        = current_attempt_next;
          result.id_valid      = 1'b1;
        end
      end
      CMD_HEARTBEAT: begin
        // a beat that goes back in time is dropped
        if ((sup_state == ST_RUNNING) && key_current && (in_data.now_ms >= last_beat)) begin
          last_beat_next = in_data.now_ms;
        end
      end
      CMD_HEALTH_CHECK, CMD_WORKER_EXITED: begin
        if (key_failed) begin
          result.action = ACT_DUP;
        end else if (!key_current) begin
          result.action = ACT_STALE;
        end else if (fail_event) begin
          failed_activation_next = in_data.activation_id;
          failed_attempt_next    = in_data.attempt_id;
          failed_known_next      = 1'b1;
          sup_state_next         = ST_STOPPED;
          if (!restart_spent) begin
            // first failure gets its one restart
            restart_spent_next  = 1'b1;
            result.restart_fire = 1'b1;
            result.action       = ACT_RESTART;
          end else if ({1'b0, in_data.now_ms} <= window_deadline) begin
            // repeat failure inside the window: crash loop, rollback once
            loop_flag_next = 1'b1;
            sup_state_next = ST_RETIRED;
            result.action  = ACT_ROLLBACK;
            if (!rollback_done) begin
              rollback_done_next   = 1'b1;
              result.rollback_fire = 1'b1;
            end
          end else begin
            // outside the window: restart and open a new window
            window_start_next   = in_data.now_ms;
            result.restart_fire = 1'b1;
            result.action       = ACT_RESTART;
          end
        end else if ((sup_state == ST_RUNNING) && (in_data.command == CMD_WORKER_EXITED)) begin
          // clean exit retires the worker
          sup_state_next = ST_RETIRED;
        end
      end
      default: begin
      end
    endcase

    if (result.restart_fire || result.rollback_fire) begin
      result.fired_activation = current_activation;
    end
    result.supervisor_state = sup_state_next;
    result.crash_loop       = loop_flag_next;
    result.attempt_active   = attempt_exists_next && (sup_state_next == ST_RUNNING);
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_timeout  <= HEARTBEAT_TIMEOUT_RESET;
      health_window      <= HEALTH_WINDOW_RESET;
      current_activation <= '0;
      current_attempt    <= '0;
      sup_state          <= ST_STOPPED;
      window_start       <= '0;
      last_beat          <= '0;
      restart_spent      <= 1'b0;
      rollback_done      <= 1'b0;
      attempt_exists     <= 1'b0;
      failed_known       <= 1'b0;
      failed_activation  <= '0;
      failed_attempt     <= '0;
      loop_flag          <= 1'b0;
      out_valid          <= 1'b0;
      skid_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEARTBEAT_TIMEOUT: heartbeat_timeout <= cfg_data;
          REG_HEALTH_WINDOW:     health_window     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (push) begin
        current_activation <= current_activation_next;
        current_attempt    <= current_attempt_next;
        sup_state          <= sup_state_next;
        window_start       <= window_start_next;
        last_beat          <= last_beat_next;
        restart_spent      <= restart_spent_next;
        rollback_done      <= rollback_done_next;
        attempt_exists     <= attempt_exists_next;
        failed_known       <= failed_known_next;
        failed_activation  <= failed_activation_next;
        failed_attempt     <= failed_attempt_next;
        loop_flag          <= loop_flag_next;
      end
      // output register refills from skid first, else from the new event
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result words, no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= result;
      end
    end else if (push) begin
      skid_data <= result;
    end
  end

  `WRS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid,
    "skid entry holds a word while the output register is empty")
  `WRS_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, out_valid && !skid_valid,
    "skid entry did not move into the output register")
  `WRS_ASSERT_NOW(a_rollback_is_loop, out_valid && out_data.rollback_fire,
    out_data.action == ACT_ROLLBACK && out_data.crash_loop && !out_data.restart_fire,
    "rollback pulse without a crash loop result")
  `WRS_ASSERT_NOW(a_restart_action, out_valid && out_data.restart_fire,
    out_data.action == ACT_RESTART && out_data.supervisor_state == ST_STOPPED,
    "restart pulse with wrong action or state")

endmodule

[test/worker_restart_supervisor_tb.sv]
// self-checking testbench for the worker restart supervisor
module worker_restart_supervisor_tb;
  import wrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // event word waiting for the driver, with the result word it must produce
  typedef struct packed {
    event_t  ev;
    result_t res;
  } staged_event_t;

  logic                     clk;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  event_t                   in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  result_t                  out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  worker_restart_supervisor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // supervisor model: its own copy of the registers and of the state
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] beat_timeout = HEARTBEAT_TIMEOUT_RESET;
  logic [TIME_BITS-1:0] window_len   = HEALTH_WINDOW_RESET;

  logic [ID_BITS-1:0]   act_id        = '0;
  logic [ID_BITS-1:0]   att_id        = '0;
  sup_state_t           sup           = ST_STOPPED;
  logic [TIME_BITS-1:0] win_start     = '0;
  logic [TIME_BITS-1:0] beat_at       = '0;
  logic                 restart_used  = 1'b0;
  logic                 rollback_sent = 1'b0;
  logic                 att_live      = 1'b0;
  logic                 fail_known    = 1'b0;
  logic [ID_BITS-1:0]   fail_act      = '0;
  logic [ID_BITS-1:0]   fail_att      = '0;
  logic                 looping       = 1'b0;

  // words in flight between the stimulus and the checker
  staged_event_t event_backlog[$];
  result_t       pending_results[$];
  int            in_flight = 0;

  // idle controls, set per stretch of stimulus
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int unsigned hold_requests = 0;

  // bookkeeping for the summary
  int unsigned failures       = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned restarts_seen  = 0;
  int unsigned rollbacks_seen = 0;
  int unsigned fallback_items = 0;

  // ids never come back to zero once they wrap
  function automatic logic [ID_BITS-1:0] bump_id(input logic [ID_BITS-1:0] id);
    return (id == '1) ? ID_BITS'(1) : id + ID_BITS'(1);
  endfunction

  // a zero in either register puts both limits back at their reset values
  function automatic logic [TIME_BITS-1:0] beat_limit_ms();
    return (beat_timeout == '0 || window_len == '0) ? HEARTBEAT_TIMEOUT_RESET : beat_timeout;
  endfunction

  function automatic logic [TIME_BITS-1:0] window_limit_ms();
    return (beat_timeout == '0 || window_len == '0) ? HEALTH_WINDOW_RESET : window_len;
  endfunction

  // current attempt failed: first failure restarts, a repeat inside the
  // window retires the worker, a repeat after it opens a new window
  function automatic logic [ACTION_BITS-1:0] note_failure(input event_t ev,
                                                          output logic rs,
                                                          output logic rb);
    logic [TIME_BITS:0] win_end;
    rs         = 1'b0;
    rb         = 1'b0;
    win_end    = {1'b0, win_start} + {1'b0, window_limit_ms()};
    fail_known = 1'b1;
    fail_act   = ev.activation_id;
    fail_att   = ev.attempt_id;
    sup        = ST_STOPPED;
    if (!restart_used) begin
      restart_used = 1'b1;
      rs = 1'b1;
      return ACT_RESTART;
    end
    if ({1'b0, ev.now_ms} <= win_end) begin
      looping = 1'b1;
      sup     = ST_RETIRED;
      if (!rollback_sent) begin
        rollback_sent = 1'b1;
        rb = 1'b1;
      end
      return ACT_ROLLBACK;
    end
    win_start = ev.now_ms;
    rs = 1'b1;
    return ACT_RESTART;
  endfunction

  // decision for one event word; updates the model state
  function automatic result_t decide_event(input event_t ev);
    result_t            r;
    logic               key_now;
    logic               key_dead;
    logic               rs;
    logic               rb;
    logic [TIME_BITS:0] beat_end;
    r        = '0;
    rs       = 1'b0;
    rb       = 1'b0;
    key_now  = att_live && ev.activation_id == act_id && ev.attempt_id == att_id;
    key_dead = fail_known && ev.activation_id == fail_act && ev.attempt_id == fail_att;
    beat_end = {1'b0, beat_at} + {1'b0, beat_limit_ms()};
    case (ev.command)
      CMD_BEGIN_ACTIVATION: begin
        act_id        = bump_id(act_id);
        sup           = ST_STOPPED;
        win_start     = ev.now_ms;
        beat_at       = ev.now_ms;
        restart_used  = 1'b0;
        rollback_sent = 1'b0;
        att_live      = 1'b0;
        fail_known    = 1'b0;
        looping       = 1'b0;
        r.id_out      = act_id;
        r.id_valid    = 1'b1;
      end
      CMD_BEGIN_ATTEMPT: begin
        if (ev.activation_id != act_id || sup != ST_STOPPED || looping) begin
          r.action = ACT_REFUSED;
        end else begin
          att_id     = bump_id(att_id);
          att_live   = 1'b1;
          sup        = ST_RUNNING;
          beat_at    = ev.now_ms;
          r.id_out   = att_id;
          r.id_valid = 1'b1;
        end
      end
      CMD_HEARTBEAT: begin
        if (sup == ST_RUNNING && key_now && ev.now_ms >= beat_at) begin
          beat_at = ev.now_ms;
        end
      end
      CMD_HEALTH_CHECK, CMD_WORKER_EXITED: begin
        if (key_dead) begin
          r.action = ACT_DUP;
        end else if (!key_now) begin
          r.action = ACT_STALE;
        end else if (sup != ST_RUNNING) begin
          r.action = ACT_NONE;
        end else if (ev.command == CMD_HEALTH_CHECK) begin
          if ({1'b0, ev.now_ms} > beat_end) begin
            r.action = note_failure(ev, rs, rb);
          end
        end else if (ev.exit_clean) begin
          sup = ST_RETIRED;
        end else begin
          r.action = note_failure(ev, rs, rb);
        end
      end
      default: begin
      end
    endcase
    r.restart_fire     = rs;
    r.rollback_fire    = rb;
    r.fired_activation = (rs || rb) ? act_id : '0;
    r.supervisor_state = sup;
    r.crash_loop       = looping;
    r.attempt_active   = att_live && sup == ST_RUNNING;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // predict in program order and hand the word to the driver
  task automatic stage(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] a,
                       input logic [ID_BITS-1:0] b, input logic [TIME_BITS-1:0] t,
                       input logic clean);
    staged_event_t s;
    s.ev.command       = cmd;
    s.ev.activation_id = a;
    s.ev.attempt_id    = b;
    s.ev.now_ms        = t;
    s.ev.exit_clean    = clean;
    if (beat_timeout == '0 || window_len == '0) fallback_items++;
    s.res = decide_event(s.ev);
    event_backlog.push_back(s);
    in_flight++;
  endtask

  // time around base+span: right at the edges, inside, well past, or soon
  function automatic logic [TIME_BITS-1:0] pick_time(input logic [TIME_BITS-1:0] base,
                                                     input logic [TIME_BITS-1:0] span);
    case ($urandom_range(0, 3))
      0: return base + span + $urandom_range(0, 2) - 32'd1;
      1: return base + ($urandom % span);
      2: return base + span + $urandom_range(2, 5000);
      default: return base + $urandom_range(0, 50);
    endcase
  endfunction

  // one random event, mostly well formed against the current state
  task automatic random_event();
    int unsigned        roll;
    logic [ID_BITS-1:0] b;
    roll = $urandom_range(0, 99);
    // a stopped or retired worker is brought back up in three rolls out of ten
    if (sup != ST_RUNNING && $urandom_range(0, 9) < 3) begin
      roll = (looping || sup == ST_RETIRED) ? 0 : 10;
    end
    if (roll < 5) begin
      stage(CMD_BEGIN_ACTIVATION, 16'($urandom), 16'($urandom),
            beat_at + $urandom_range(0, 2000), 1'($urandom));
    end else if (roll < 20) begin
      stage(CMD_BEGIN_ATTEMPT, ($urandom_range(0, 9) == 0) ? 16'($urandom) : act_id,
            16'($urandom), beat_at + $urandom_range(0, 300), 1'($urandom));
    end else if (roll < 45) begin
      b = ($urandom_range(0, 7) == 0) ? 16'($urandom) : att_id;
      stage(CMD_HEARTBEAT, act_id, b,
            ($urandom_range(0, 7) == 0) ? beat_at - $urandom_range(1, 100)
                                        : beat_at + $urandom_range(0, 400),
            1'($urandom));
    end else if (roll < 65) begin
      stage(CMD_HEALTH_CHECK, act_id, att_id, pick_time(beat_at, beat_limit_ms()),
            1'($urandom));
    end else if (roll < 80) begin
      stage(CMD_WORKER_EXITED, act_id, att_id, pick_time(win_start, window_limit_ms()),
            $urandom_range(0, 3) == 0);
    end else if (roll < 90) begin
      // repeat report on the failed key, or an older attempt
      if ($urandom_range(0, 1) == 1) begin
        stage($urandom_range(0, 1) ? CMD_HEALTH_CHECK : CMD_WORKER_EXITED, fail_act, fail_att,
              beat_at + $urandom_range(0, 5000), 1'($urandom));
      end else begin
        stage($urandom_range(0, 1) ? CMD_HEALTH_CHECK : CMD_WORKER_EXITED, act_id,
              att_id - 16'd1, beat_at + $urandom_range(0, 5000), 1'($urandom));
      end
    end else begin
      // noise: anything the fields allow, unknown commands included
      stage(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 32'($urandom),
            1'($urandom));
    end
  endtask

  // sender pauses until every expected result word is back
  task automatic wait_idle();
    while (in_flight != 0 || event_backlog.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_HEARTBEAT_TIMEOUT) begin
      beat_timeout = val;
    end else begin
      window_len = val;
    end
  endtask

  // random events in stretches of 50, each stretch with its own idle mix;
  // the first stretch runs flat out, optionally against a long output hold-off
  task automatic random_phase(input int unsigned count, input bit squeeze);
    int unsigned n;
    n = 0;
    while (n < count) begin
      if (n == 0) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      repeat (50) random_event();
      if (squeeze && n == 0) hold_requests++;
      n += 50;
      while (event_backlog.size() > 8) @(posedge clk);
    end
    wait_idle();
  endtask

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and the watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d result words outstanding", in_flight);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: offers the backlog one event word at a time
  // ---------------------------------------------------------------------------
  result_t     offered_result;
  int unsigned tx_wait = 0;

  always @(posedge clk) begin : send
    staged_event_t s;
    logic          next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      // word taken: its expectation goes in line and the next gap is drawn
      if (in_valid && !in_stall) begin
        pending_results.push_back(offered_result);
        items_sent++;
        next_valid = 1'b0;
        tx_wait    = tx_idle ? $urandom_range(0, 11) : 0;
      end
      // a stalled word stays put; a new one only goes up once the bus is free
      if (!next_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (event_backlog.size() != 0) begin
          s              = event_backlog.pop_front();
          in_data       <= s.ev;
          offered_result = s.res;
          next_valid     = 1'b1;
        end
      end
    end
    // single nonblocking write so a back-to-back word keeps valid high
    in_valid <= next_valid;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result word and draws the output stall
  // ---------------------------------------------------------------------------
  int unsigned rx_wait   = 0;
  int unsigned rx_hold   = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk) begin : receive
    result_t want;
    logic    next_stall;
    next_stall = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.restart_fire) restarts_seen++;
        if (out_data.rollback_fire) rollbacks_seen++;
        if (pending_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("action", 32'(want.action), 32'(out_data.action));
          check_field("id_out", 32'(want.id_out), 32'(out_data.id_out));
          check_field("id_valid", 32'(want.id_valid), 32'(out_data.id_valid));
          check_field("restart_fire", 32'(want.restart_fire), 32'(out_data.restart_fire));
          check_field("rollback_fire", 32'(want.rollback_fire), 32'(out_data.rollback_fire));
          check_field("fired_activation", 32'(want.fired_activation),
                      32'(out_data.fired_activation));
          check_field("supervisor_state", 32'(want.supervisor_state),
                      32'(out_data.supervisor_state));
          check_field("crash_loop", 32'(want.crash_loop), 32'(out_data.crash_loop));
          check_field("attempt_active", 32'(want.attempt_active), 32'(out_data.attempt_active));
          in_flight--;
        end
        rx_wait = rx_idle ? $urandom_range(0, 11) : 0;
      end
      // long hold-off: lets the output register and skid entry fill so the
      // block has to stall its input while the driver keeps offering
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        rx_hold   = 150;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        next_stall = 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        next_stall = 1'b1;
      end
    end
    out_stall <= next_stall;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, registers at reset values
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    stage(CMD_HEALTH_CHECK, 16'd0, 16'd0, 32'd0, 1'b0);          // no attempt yet: stale
    stage(CMD_BEGIN_ATTEMPT, 16'd0, 16'd0, 32'd0, 1'b0);         // activation zero accepted
    stage(CMD_BEGIN_ACTIVATION, 16'd0, 16'd0, 32'd100, 1'b0);
    stage(CMD_BEGIN_ATTEMPT, 16'hFFFF, 16'hFFFF, 32'd100, 1'b1); // wrong activation
    stage(CMD_BEGIN_ATTEMPT, 16'd1, 16'd0, 32'd100, 1'b0);
    stage(CMD_BEGIN_ATTEMPT, 16'd1, 16'd0, 32'd150, 1'b0);       // already running
    stage(CMD_HEARTBEAT, 16'd1, 16'd2, 32'd600, 1'b0);
    stage(CMD_HEARTBEAT, 16'd1, 16'd2, 32'd300, 1'b0);           // going back in time
    stage(CMD_HEALTH_CHECK, 16'd1, 16'd2, 32'd1600, 1'b0);       // right at the limit
    stage(CMD_HEALTH_CHECK, 16'd1, 16'd2, 32'd1601, 1'b0);       // missed: restart
    stage(CMD_HEALTH_CHECK, 16'd1, 16'd2, 32'd1700, 1'b0);       // same failure again
    stage(CMD_BEGIN_ATTEMPT, 16'd1, 16'd0, 32'd1800, 1'b1);
    stage(CMD_WORKER_EXITED, 16'd1, 16'd3, 32'd2000, 1'b0);      // second failure: rollback
    stage(CMD_WORKER_EXITED, 16'd1, 16'd3, 32'd2001, 1'b1);
    stage(CMD_BEGIN_ATTEMPT, 16'd1, 16'd0, 32'd2100, 1'b0);      // refused in crash loop
    stage(3'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);        // unknown commands
    stage(3'd7, 16'h5A5A, 16'hA5A5, 32'h1234_5678, 1'b0);
    stage(CMD_BEGIN_ACTIVATION, 16'd0, 16'd0, 32'd20000, 1'b0);
    stage(CMD_BEGIN_ATTEMPT, 16'd2, 16'd0, 32'd20000, 1'b0);
    stage(CMD_WORKER_EXITED, 16'd2, 16'd4, 32'd20010, 1'b0);
    stage(CMD_BEGIN_ATTEMPT, 16'd2, 16'd0, 32'd20020, 1'b0);
    stage(CMD_WORKER_EXITED, 16'd2, 16'd5, 32'd30001, 1'b0);     // past the window: restart
    stage(CMD_BEGIN_ATTEMPT, 16'd2, 16'd0, 32'd30002, 1'b0);
    stage(CMD_WORKER_EXITED, 16'd2, 16'd6, 32'd30003, 1'b1);     // clean exit retires
    stage(CMD_BEGIN_ACTIVATION, 16'd0, 16'd0, 32'hFFFF_FF00, 1'b0);
    stage(CMD_BEGIN_ATTEMPT, 16'd3, 16'd0, 32'hFFFF_FF00, 1'b0);
    stage(CMD_HEALTH_CHECK, 16'd3, 16'd7, 32'hFFFF_FFFF, 1'b0);  // sum must not wrap
    wait_idle();

    // random phases across register settings, extremes included
    random_phase(300, 1'b1);
    write_reg(REG_HEARTBEAT_TIMEOUT, 32'd1);
    write_reg(REG_HEALTH_WINDOW, 32'd1);
    random_phase(200, 1'b0);
    write_reg(REG_HEARTBEAT_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(REG_HEALTH_WINDOW, 32'hFFFF_FFFF);
    random_phase(150, 1'b0);
    // a zero register puts both limits on their fallback values
    write_reg(REG_HEARTBEAT_TIMEOUT, 32'd0);
    write_reg(REG_HEALTH_WINDOW, $urandom_range(1, 500));
    random_phase(150, 1'b0);
    write_reg(REG_HEARTBEAT_TIMEOUT, $urandom_range(1, 3000));
    write_reg(REG_HEALTH_WINDOW, 32'd0);
    random_phase(100, 1'b0);
    write_reg(REG_HEARTBEAT_TIMEOUT, $urandom_range(2, 5000));
    write_reg(REG_HEALTH_WINDOW, $urandom_range(100, 60000));
    random_phase(250, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);

    $display("%0d events checked against %0d result words (%0d under fallback limits)",
             items_sent, results_seen, fallback_items);
    $display("%0d restart and %0d rollback pulses seen across six register settings",
             restarts_seen, rollbacks_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
